FILE: rtl/min_max_peak_decimator_macros.svh
// Assertion helpers shared by the peak decimator RTL
`ifndef MIN_MAX_PEAK_DECIMATOR_MACROS_SVH
`define MIN_MAX_PEAK_DECIMATOR_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define MMPD_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition
`define MMPD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mmpd_pkg.sv
package mmpd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEN_W       = 16;
  localparam int POINT_W     = 24;
  localparam int QUEUE_DEPTH = 4;

  // One closed block, ready to be sent as one or two points
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_amp;
    logic                       first_is_max;
    logic signed [SAMPLE_W-1:0] second_amp;
    logic                       two_points;
    logic                       eod;
  } block_rec_t;

endpackage

FILE: rtl/mmpd_front.sv
`include "min_max_peak_decimator_macros.svh"

module mmpd_front #(
  parameter int BLOCK_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mmpd_pkg::LEN_W-1:0]          blk_len,
  input  logic                                accept,
  input  logic signed [mmpd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                end_of_data,
  output logic                                rec_push,
  output mmpd_pkg::block_rec_t                rec
);

  localparam int CNT_W = BLOCK_BITS + 1;
  localparam int CMP_W = (CNT_W > mmpd_pkg::LEN_W) ? CNT_W : mmpd_pkg::LEN_W;

  logic [BLOCK_BITS-1:0]                cnt;
  logic signed [mmpd_pkg::SAMPLE_W-1:0] run_max;
  logic signed [mmpd_pkg::SAMPLE_W-1:0] run_min;
  logic [BLOCK_BITS-1:0]                max_pos;
  logic [BLOCK_BITS-1:0]                min_pos;

  logic                                 first;
  logic                                 up_max;
  logic                                 up_min;
  logic signed [mmpd_pkg::SAMPLE_W-1:0] max_next;
  logic signed [mmpd_pkg::SAMPLE_W-1:0] min_next;
  logic [BLOCK_BITS-1:0]                max_pos_next;
  logic [BLOCK_BITS-1:0]                min_pos_next;
  logic [CNT_W-1:0]                     count;
  logic [mmpd_pkg::LEN_W-1:0]           len_eff;
  logic                                 close;
  logic                                 max_first;

  // Fold the new sample into the running extremes; first occurrence wins ties
  always_comb begin
    first        = (cnt == '0);
    up_max       = (sample > run_max);
    up_min       = (sample < run_min);
    max_next     = (first || up_max) ? sample : run_max;
    min_next     = (first || up_min) ? sample : run_min;
    max_pos_next = first ? '0 : (up_max ? cnt : max_pos);
    min_pos_next = first ? '0 : (up_min ? cnt : min_pos);
  end

  // Close the block on end of data, on reaching the length, or on counter overflow
  always_comb begin
    count   = CNT_W'(cnt) + CNT_W'(1);
    len_eff = (blk_len == '0) ? mmpd_pkg::LEN_W'(1) : blk_len;
    close   = end_of_data || (CMP_W'(count) >= CMP_W'(len_eff)) || count[BLOCK_BITS];
  end

  // Order the two extremes by where they first appeared
  always_comb begin
    max_first       = (max_pos_next < min_pos_next);
    rec.first_amp    = max_first ? max_next : min_next;
    rec.first_is_max = max_first;
    rec.second_amp   = max_first ? min_next : max_next;
    rec.two_points   = (max_pos_next != min_pos_next);
    rec.eod          = end_of_data;
    rec_push         = accept && close;
  end

  // Advance the block counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= close ? '0 : count[BLOCK_BITS-1:0];
    end
  end

  // Hold the running extremes
  always_ff @(posedge clk) begin
    if (accept) begin
      run_max <= max_next;
      run_min <= min_next;
      max_pos <= max_pos_next;
      min_pos <= min_pos_next;
    end
  end

  `MMPD_ASSERT_NEXT(a_close_restarts, clk, rst, rec_push, cnt == '0, "block did not restart")

endmodule

FILE: rtl/mmpd_queue.sv
`include "min_max_peak_decimator_macros.svh"

module mmpd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mmpd_pkg::block_rec_t wr_rec,
  output logic                 full,
  input  logic                 pop,
  output mmpd_pkg::block_rec_t rd_rec,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mmpd_pkg::block_rec_t  slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = slots[rd_ptr];

  // Store a request at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `MMPD_ASSERT_NOW(a_no_overrun, clk, rst, full, !push, "push into full block queue")

endmodule

FILE: rtl/mmpd_back.sv
`include "min_max_peak_decimator_macros.svh"

module mmpd_back #(
  parameter int INDEX_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mmpd_pkg::block_rec_t                 q_rec,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [mmpd_pkg::POINT_W-1:0]         point_index,
  output logic signed [mmpd_pkg::SAMPLE_W-1:0] amplitude,
  output logic                                 is_maximum,
  output logic                                 last
);

  mmpd_pkg::block_rec_t                 rec;
  logic                                 rec_valid;
  logic                                 phase;
  logic [INDEX_BITS-1:0]                next_point;
  logic                                 out_valid;

  logic                                 load;
  logic                                 rec_done;
  logic                                 eod_done;
  logic signed [mmpd_pkg::SAMPLE_W-1:0] pt_amp;
  logic                                 pt_is_max;
  logic                                 pt_last;

  // Pick the point of the current block request
  always_comb begin
    pt_amp    = phase ? rec.second_amp : rec.first_amp;
    pt_is_max = phase ? !rec.first_is_max : rec.first_is_max;
    pt_last   = phase || !rec.two_points;
    load      = rec_valid && (!out_valid || pop);
    rec_done  = load && pt_last;
    eod_done  = rec_done && rec.eod;
    q_pop     = !q_empty && (!rec_valid || rec_done);
    empty     = !out_valid;
  end

  // Hold the block request being sent
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec <= q_rec;
    end
  end

  // Track which point of the request goes out next
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (q_pop) begin
        rec_valid <= 1'b1;
      end else if (rec_done) begin
        rec_valid <= 1'b0;
      end
      if (q_pop || rec_done) begin
        phase <= 1'b0;
      end else if (load) begin
        phase <= 1'b1;
      end
    end
  end

  // Advance the point index; restart it after end of data
  always_ff @(posedge clk) begin
    if (rst) begin
      next_point <= '0;
    end else if (load) begin
      next_point <= (pt_last && rec.eod) ? '0 : next_point + INDEX_BITS'(1);
    end
  end

  // Output register: parts the queue from the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the next point into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      point_index <= mmpd_pkg::POINT_W'(next_point);
      amplitude   <= pt_amp;
      is_maximum  <= pt_is_max;
      last        <= pt_last;
    end
  end

  `MMPD_ASSERT_NEXT(a_eod_restart, clk, rst, eod_done, next_point == '0, "index did not restart")
  `MMPD_ASSERT_NOW(a_pair_phase, clk, rst, rec_valid && phase, rec.two_points, "bad phase")

endmodule

FILE: rtl/min_max_peak_decimator.sv
// Channel  | Request            | Accepted when  | Payload
// ---------+--------------------+----------------+------------------------------------------
// input    | push / full        | push && !full  | sample, end_of_data
// result   | empty / pop        | pop && !empty  | point_index, amplitude, is_maximum, last
// config   | cfg_write          | cfg_write      | block_length
//
// One sample is taken per cycle while full is low. A closing sample's first point
// passes the block queue, the held block request and the output register to the
// result ports; a second point follows once the first is taken. A block never
// yields more points than it has samples, so with pop held high a sample is taken
// every cycle at any block length. A four-entry block queue lets the input run
// while results are stalled; full rises only when it is filled. Reset is synchronous.
module min_max_peak_decimator #(
  parameter int BLOCK_BITS = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmpd_pkg::LEN_W-1:0]           block_length,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [mmpd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 end_of_data,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [mmpd_pkg::POINT_W-1:0]         point_index,
  output logic signed [mmpd_pkg::SAMPLE_W-1:0] amplitude,
  output logic                                 is_maximum,
  output logic                                 last
);

  logic [mmpd_pkg::LEN_W-1:0] blk_len;
  logic                       accept;
  logic                       rec_push;
  mmpd_pkg::block_rec_t       front_rec;
  mmpd_pkg::block_rec_t       back_rec;
  logic                       q_empty;
  logic                       q_pop;

  // Hold the block length register
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_len <= mmpd_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      blk_len <= block_length;
    end
  end

  assign accept = push && !full;

  mmpd_front #(
    .BLOCK_BITS (BLOCK_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .blk_len     (blk_len),
    .accept      (accept),
    .sample      (sample),
    .end_of_data (end_of_data),
    .rec_push    (rec_push),
    .rec         (front_rec)
  );

  mmpd_queue #(
    .DEPTH (mmpd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (front_rec),
    .full   (full),
    .pop    (q_pop),
    .rd_rec (back_rec),
    .empty  (q_empty)
  );

  mmpd_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rec       (back_rec),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .point_index (point_index),
    .amplitude   (amplitude),
    .is_maximum  (is_maximum),
    .last        (last)
  );

endmodule

FILE: tb/sv/min_max_peak_decimator_test.sv
module min_max_peak_decimator_test;
  import mmpd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam logic [LEN_W:0] COUNT_MAX = {1'b0, {LEN_W{1'b1}}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic [POINT_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] amp;
    logic                       is_max;
    logic                       final_point;
  } peak_point_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [LEN_W-1:0]           block_length = 16'd1;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       end_of_data = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [POINT_W-1:0]         point_index;
  logic signed [SAMPLE_W-1:0] amplitude;
  logic                       is_maximum;
  logic                       last;

  // Predictor state
  logic [LEN_W-1:0]           cur_len = 16'd1;
  logic [LEN_W-1:0]           blk_count = '0;
  logic signed [SAMPLE_W-1:0] run_max = '0;
  logic signed [SAMPLE_W-1:0] run_min = '0;
  logic [LEN_W-1:0]           max_pos = '0;
  logic [LEN_W-1:0]           min_pos = '0;
  logic [POINT_W-1:0]         point_ctr = '0;

  peak_point_t                expected_points[$];
  peak_point_t                head_point;
  logic signed [SAMPLE_W-1:0] prev_sample = '0;
  int                         mismatch_count = 0;
  int                         cycle_count = 0;
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;

  min_max_peak_decimator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .block_length (block_length),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .end_of_data  (end_of_data),
    .empty        (empty),
    .pop          (pop),
    .point_index  (point_index),
    .amplitude    (amplitude),
    .is_maximum   (is_maximum),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("min_max_peak_decimator: mismatch");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Compare each accepted point with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point index=%0d amp=%0d",
                                  point_index, amplitude));
      end else begin
        head_point = expected_points.pop_front();
        if (point_index !== head_point.index)
          report_mismatch($sformatf("point_index %0d, want %0d",
                                    point_index, head_point.index));
        if (amplitude !== head_point.amp)
          report_mismatch($sformatf("amplitude %0d, want %0d",
                                    amplitude, head_point.amp));
        if (is_maximum !== head_point.is_max)
          report_mismatch($sformatf("is_maximum %b, want %b",
                                    is_maximum, head_point.is_max));
        if (last !== head_point.final_point)
          report_mismatch($sformatf("last %b, want %b",
                                    last, head_point.final_point));
      end
    end
  end

  function automatic void add_point(input logic signed [SAMPLE_W-1:0] amp,
                                    input logic is_max, input logic final_point);
    peak_point_t pt;
    pt.index       = point_ctr;
    pt.amp         = amp;
    pt.is_max      = is_max;
    pt.final_point = final_point;
    expected_points = {expected_points, pt};
    point_ctr = point_ctr + 1'b1;
  endfunction

  // Track the running extremes and emit the one or two peak points when a block closes
  task automatic predict_points(input logic signed [SAMPLE_W-1:0] s, input logic eod);
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   count;
    len = (cur_len == '0) ? 16'd1 : cur_len;
    if (blk_count == '0) begin
      run_max = s;
      run_min = s;
      max_pos = '0;
      min_pos = '0;
    end else begin
      if (s > run_max) begin
        run_max = s;
        max_pos = blk_count;
      end
      if (s < run_min) begin
        run_min = s;
        min_pos = blk_count;
      end
    end
    count = {1'b0, blk_count} + 1'b1;
    if (!eod && count < {1'b0, len} && count <= COUNT_MAX) begin
      blk_count = count[LEN_W-1:0];
      return;
    end
    if (max_pos < min_pos) begin
      add_point(run_max, 1'b1, 1'b0);
      add_point(run_min, 1'b0, 1'b1);
    end else if (max_pos > min_pos) begin
      add_point(run_min, 1'b0, 1'b0);
      add_point(run_max, 1'b1, 1'b1);
    end else begin
      add_point(run_min, 1'b0, 1'b1);
    end
    blk_count = '0;
    if (eod) point_ctr = '0;
  endtask

  // Offer one sample request, hold it until accepted, then predict
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eod);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push        <= 1'b1;
    sample      <= s;
    end_of_data <= eod;
    do @(posedge clk); while (full);
    predict_points(s, eod);
    prev_sample = s;
  endtask

  // Hold off input until every predicted point has come out
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_write    <= 1'b1;
    block_length <= len;
    @(posedge clk);
    cur_len = len;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int mode;
    mode = $urandom_range(99);
    if (mode < 8) return 16'sh8000;
    if (mode < 16) return 16'sh7FFF;
    if (mode < 36) return prev_sample;
    if (mode < 56) return SAMPLE_W'($signed($urandom_range(8)) - 4);
    return SAMPLE_W'($urandom);
  endfunction

  // Reset length is one: every sample is its own single-point block
  task automatic test_default_length();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  // A zero length acts as one
  task automatic test_zero_length();
    write_block_length(16'd0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b1);
  endtask

  // Emit order, first-occurrence ties, single point, early close on end of data
  task automatic test_order_and_ties();
    write_block_length(16'd4);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd9, 1'b1);
  endtask

  // Longest block length, closed by end of data
  task automatic test_longest_block();
    write_block_length(LEN_MAX);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  // Random blocks under changing lengths, with drains between settings
  task automatic test_random_stream(input int n_items);
    int left;
    int seg;
    int pick;
    logic [LEN_W-1:0] len;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 30) len = 16'd1;
      else if (pick < 70) len = LEN_W'($urandom_range(8, 2));
      else if (pick < 85) len = LEN_W'($urandom_range(40, 9));
      else if (pick < 92) len = 16'd0;
      else len = LEN_MAX;
      write_block_length(len);
      seg = $urandom_range(60, 4);
      if (seg > left) seg = left;
      for (int i = 0; i < seg; i++) begin
        send_sample(pick_sample(),
                    ($urandom_range(99) < 3) ||
                    (i == seg - 1 && len == LEN_MAX && $urandom_range(1) == 1));
      end
      left -= seg;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 51;
    test_default_length();
    test_zero_length();
    test_order_and_ties();
    test_longest_block();
    test_random_stream(630);

    send_idle_pct = 51;
    recv_idle_pct = 31;
    test_random_stream(630);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(630);

    // Let the pipeline empty and catch any stray point
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("min_max_peak_decimator: match");
    end else begin
      $display("min_max_peak_decimator: mismatch");
    end
    $finish;
  end

endmodule
